[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the label overlap resolver.
// No dependencies. Define SYNTH to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check a condition at every clock edge outside reset.
`define LOR_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Check that an antecedent implies a consequent in the following cycle.
`define LOR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LOR_ASSERT(lbl, cond, msg)
`define LOR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/lor_pkg.sv]
// Package for the label overlap resolver: sequencer states, register map,
// field widths and reset values. No dependencies.
package lor_pkg;

  localparam int unsigned COORD_W  = 16;
  localparam int unsigned WIDTH_W  = 14;
  localparam int unsigned HEIGHT_W = 14;
  localparam int unsigned PAD_W    = 12;
  localparam int unsigned GAP_W    = 15;  // size + padding, unsigned
  localparam int unsigned ADDR_W   = 4;   // three registers at 0, 4, 8
  localparam int unsigned DATA_W   = 32;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 14'd1600;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 14'd320;
  localparam logic [PAD_W-1:0]    PAD_RST    = 12'd64;

  typedef enum logic [1:0] {
    REG_WIDTH   = 2'd0,
    REG_HEIGHT  = 2'd1,
    REG_PADDING = 2'd2,
    REG_NONE    = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } pos_t;

endpackage

[rtl/label_overlap_resolver.sv]
// Top level of the label overlap resolver: stream ports, APB register file,
// scan sequencer and position store. Depends on lor_pkg and assert_macros.svh.
//
// Labels arrive nearest first; each is checked against the labels already placed
// in the frame and pushed up above the first one it overlaps, then the scan
// restarts, for at most MAX_PASSES passes. The resolved position is sent out and
// appended to the store (up to MAX_LABELS entries; past that store_full is set
// and the label is not kept). in_tlast ends the frame and empties the store.
// Timing: the store is a single-port memory with registered read, scanned one
// entry a cycle by one shared overlap/push unit. With an empty store the scan is
// skipped. The next label is taken once the result sits in the output register;
// the output register frees on its transfer out.
`include "assert_macros.svh"

module label_overlap_resolver #(
  parameter int unsigned MAX_LABELS = 64,
  parameter int unsigned MAX_PASSES = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,   // [15:0] anchor_x, [31:16] anchor_y
  input  logic                          in_tlast,   // frame_end
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [31:0]                   out_tdata,  // [15:0] placed_x, [31:16] placed_y
  output logic                          out_tuser,  // store_full
  output logic                          out_tlast,  // frame_last
  // configuration
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [lor_pkg::ADDR_W-1:0]    cfg_paddr,
  input  logic [lor_pkg::DATA_W-1:0]    cfg_pwdata,
  output logic [lor_pkg::DATA_W-1:0]    cfg_prdata,
  output logic                          cfg_pready
);
  import lor_pkg::*;

  localparam int unsigned AW = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
  localparam int unsigned CW = $clog2(MAX_LABELS + 1);
  localparam int unsigned PW = $clog2(MAX_PASSES + 1);
  localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_LABELS);
  localparam logic [PW-1:0] PASS_MAX = PW'(MAX_PASSES);

  // ---------------- configuration registers ----------------
  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic [PAD_W-1:0]    pad_r;
  reg_idx_t            cfg_idx;
  logic                cfg_wr;

  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      pad_r    <= PAD_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WIDTH:   width_r  <= cfg_pwdata[WIDTH_W-1:0];
        REG_HEIGHT:  height_r <= cfg_pwdata[HEIGHT_W-1:0];
        REG_PADDING: pad_r    <= cfg_pwdata[PAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_WIDTH:   cfg_prdata = DATA_W'(width_r);
      REG_HEIGHT:  cfg_prdata = DATA_W'(height_r);
      REG_PADDING: cfg_prdata = DATA_W'(pad_r);
      default:     cfg_prdata = '0;
    endcase
  end

  // gaps for the overlap test and the push distance
  logic [GAP_W-1:0] gap_x;
  logic [GAP_W-1:0] gap_y;
  assign gap_x = GAP_W'(width_r) + GAP_W'(pad_r);
  assign gap_y = GAP_W'(height_r) + GAP_W'(pad_r);

  // ---------------- sequencer state ----------------
  state_t                     state_r, state_nxt;
  logic signed [COORD_W-1:0]  x_r, x_nxt;
  logic signed [COORD_W-1:0]  y_r, y_nxt;
  logic                       last_r, last_nxt;
  logic [CW-1:0]              count_r, count_nxt;   // labels held in the store
  logic [CW-1:0]              idx_r, idx_nxt;       // next entry to read
  logic                       cmp_vld_r, cmp_vld_nxt; // read data is live
  logic [PW-1:0]              pass_r, pass_nxt;     // pushes so far

  logic                       out_vld_r, out_vld_nxt;
  pos_t                       out_pos_r, out_pos_nxt;
  logic                       out_full_r, out_full_nxt;
  logic                       out_last_r, out_last_nxt;

  // ---------------- position store ----------------
  pos_t        mem_r [MAX_LABELS];
  pos_t        rd_data_r;
  logic        rd_en;
  logic [AW-1:0] rd_addr;
  logic        wr_en;

  assign rd_addr = idx_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[count_r[AW-1:0]] <= '{x: x_r, y: y_r};
    end
  end

  // ---------------- shared overlap / push unit ----------------
  logic signed [COORD_W:0]   dx, dy;
  logic [COORD_W:0]          adx, ady;
  logic                      hit;
  logic signed [COORD_W+1:0] push_y;
  logic signed [COORD_W-1:0] push_sat;

  always_comb begin
    dx  = {x_r[COORD_W-1], x_r} - {rd_data_r.x[COORD_W-1], rd_data_r.x};
    dy  = {y_r[COORD_W-1], y_r} - {rd_data_r.y[COORD_W-1], rd_data_r.y};
    adx = dx[COORD_W] ? (COORD_W+1)'(-dx) : (COORD_W+1)'(dx);
    ady = dy[COORD_W] ? (COORD_W+1)'(-dy) : (COORD_W+1)'(dy);
    hit = cmp_vld_r && (adx < (COORD_W+1)'(gap_x)) && (ady < (COORD_W+1)'(gap_y));
    // push: stored y minus (height + padding), clamped at the most negative value
    push_y = {{2{rd_data_r.y[COORD_W-1]}}, rd_data_r.y} - $signed({3'b000, gap_y});
    if (push_y < -(COORD_W+2)'(32768)) begin
      push_sat = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      push_sat = push_y[COORD_W-1:0];
    end
  end

  // ---------------- next state ----------------
  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    last_nxt     = last_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    cmp_vld_nxt  = cmp_vld_r;
    pass_nxt     = pass_r;
    out_vld_nxt  = out_vld_r;
    out_pos_nxt  = out_pos_r;
    out_full_nxt = out_full_r;
    out_last_nxt = out_last_r;
    rd_en        = 1'b0;
    wr_en        = 1'b0;

    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          x_nxt       = in_tdata[15:0];
          y_nxt       = in_tdata[31:16];
          last_nxt    = in_tlast;
          idx_nxt     = '0;
          cmp_vld_nxt = 1'b0;
          pass_nxt    = '0;
          state_nxt   = (count_r == '0) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          // move above the overlapped label, start a fresh pass
          y_nxt       = push_sat;
          pass_nxt    = pass_r + 1'b1;
          idx_nxt     = '0;
          cmp_vld_nxt = 1'b0;
          if (pass_r + 1'b1 == PASS_MAX) begin
            state_nxt = ST_DONE;
          end
        end else if (cmp_vld_r && idx_r == count_r) begin
          // last entry compared clean
          cmp_vld_nxt = 1'b0;
          state_nxt   = ST_DONE;
        end else begin
          rd_en       = 1'b1;
          idx_nxt     = idx_r + 1'b1;
          cmp_vld_nxt = 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt  = 1'b1;
          out_pos_nxt  = '{x: x_r, y: y_r};
          out_full_nxt = (count_r == CNT_MAX);
          out_last_nxt = last_r;
          if (count_r != CNT_MAX) begin
            wr_en     = 1'b1;
            count_nxt = count_r + 1'b1;
          end
          if (last_r) begin
            count_nxt = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      out_vld_r <= 1'b0;
      cmp_vld_r <= 1'b0;
      pass_r    <= '0;
      idx_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      out_vld_r <= out_vld_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      pass_r    <= pass_nxt;
      idx_r     <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    last_r     <= last_nxt;
    out_pos_r  <= out_pos_nxt;
    out_full_r <= out_full_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_pos_r.y, out_pos_r.x};
  assign out_tuser  = out_full_r;
  assign out_tlast  = out_last_r;

  // ---------------- checks ----------------
  `LOR_ASSERT(a_count_bound, count_r <= CNT_MAX, "store count past capacity")
  `LOR_ASSERT(a_no_write_full, !wr_en || count_r < CNT_MAX, "store write while full")
  `LOR_ASSERT(a_pass_bound, state_r != ST_SCAN || pass_r < PASS_MAX, "scan past pass limit")
  `LOR_ASSERT_NEXT(a_accept_busy, in_tvalid && in_tready, state_r != ST_IDLE, "idle after transfer in")

endmodule

[test/label_placement_checker.sv]
// Scoreboard for the label overlap resolver: watches the register port and both
// streams, predicts every placement and compares it field by field.
// Depends on lor_pkg.
module label_placement_checker #(
  parameter int unsigned MAX_LABELS = 64,
  parameter int unsigned MAX_PASSES = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [31:0]                in_tdata,   // [15:0] anchor_x, [31:16] anchor_y
  input  logic                       in_tlast,   // frame_end
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [31:0]                out_tdata,  // [15:0] placed_x, [31:16] placed_y
  input  logic                       out_tuser,  // store_full
  input  logic                       out_tlast,  // frame_last
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [lor_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [lor_pkg::DATA_W-1:0] cfg_pwdata,
  input  logic [lor_pkg::DATA_W-1:0] cfg_prdata,
  input  logic                       cfg_pready,
  output int                         fail_count,
  output int                         labels_in_flight
);
  import lor_pkg::*;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      full;
    logic                      last;
  } placement_t;

  placement_t                placements_due[$];
  logic signed [COORD_W-1:0] kept_x [MAX_LABELS];
  logic signed [COORD_W-1:0] kept_y [MAX_LABELS];
  int unsigned               kept_count;
  logic [WIDTH_W-1:0]        width_q;
  logic [HEIGHT_W-1:0]       height_q;
  logic [PAD_W-1:0]          pad_q;

  // Push the label above the first kept label it overlaps, rescan, then keep it if the store has room.
  function automatic placement_t resolve_label(input logic signed [COORD_W-1:0] ax,
                                               input logic signed [COORD_W-1:0] ay,
                                               input logic fe);
    int          x, y, gx, gy, dx, dy, px, py;
    int unsigned n, pass, j;
    logic        hit;
    placement_t  res;
    x  = int'(ax);
    y  = int'(ay);
    gx = int'(width_q) + int'(pad_q);
    gy = int'(height_q) + int'(pad_q);
    n  = kept_count;
    hit = 1'b1;
    for (pass = 0; pass < MAX_PASSES && hit; pass++) begin
      hit = 1'b0;
      for (j = 0; j < n && !hit; j++) begin
        px = int'(kept_x[j]);
        py = int'(kept_y[j]);
        dx = (x > px) ? x - px : px - x;
        dy = (y > py) ? y - py : py - y;
        if (dx < gx && dy < gy) begin
          y = py - gy;
          if (y < -32768) y = -32768;
          hit = 1'b1;
        end
      end
    end
    res.x    = ax;
    res.y    = y[COORD_W-1:0];
    res.full = (n >= MAX_LABELS);
    res.last = fe;
    if (n < MAX_LABELS) begin
      kept_x[n]  = ax;
      kept_y[n]  = y[COORD_W-1:0];
      kept_count = n + 1;
    end
    if (fe) kept_count = 0;
    return res;
  endfunction

  always @(posedge clk) begin
    placement_t        got, want;
    logic [DATA_W-1:0] rd_want;
    logic              rd_known;
    int                nfail;
    nfail = 0;
    if (!rst_n) begin
      placements_due.delete();
      kept_count = 0;
      width_q    = WIDTH_RST;
      height_q   = HEIGHT_RST;
      pad_q      = PAD_RST;
      fail_count       <= 0;
      labels_in_flight <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.x    = out_tdata[15:0];
        got.y    = out_tdata[31:16];
        got.full = out_tuser;
        got.last = out_tlast;
        if (placements_due.size() == 0) begin
          nfail++;
          $error("placement with no label pending: x=%0d y=%0d", got.x, got.y);
        end else begin
          want = placements_due.pop_front();
          if (got.x !== want.x) begin
            nfail++;
            $error("placed_x: expected %0d, got %0d", want.x, got.x);
          end
          if (got.y !== want.y) begin
            nfail++;
            $error("placed_y: expected %0d, got %0d", want.y, got.y);
          end
          if (got.full !== want.full) begin
            nfail++;
            $error("store_full: expected %0d, got %0d", want.full, got.full);
          end
          if (got.last !== want.last) begin
            nfail++;
            $error("frame_last: expected %0d, got %0d", want.last, got.last);
          end
        end
      end

      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          case (reg_idx_t'(cfg_paddr[3:2]))
            REG_WIDTH:   width_q  = cfg_pwdata[WIDTH_W-1:0];
            REG_HEIGHT:  height_q = cfg_pwdata[HEIGHT_W-1:0];
            REG_PADDING: pad_q    = cfg_pwdata[PAD_W-1:0];
            default: ;
          endcase
        end else begin
          rd_known = 1'b1;
          rd_want  = '0;
          case (reg_idx_t'(cfg_paddr[3:2]))
            REG_WIDTH:   rd_want = DATA_W'(width_q);
            REG_HEIGHT:  rd_want = DATA_W'(height_q);
            REG_PADDING: rd_want = DATA_W'(pad_q);
            default:     rd_known = 1'b0;
          endcase
          if (rd_known && cfg_prdata !== rd_want) begin
            nfail++;
            $error("register %0d readback: expected %0d, got %0d",
                   cfg_paddr[3:2], rd_want, cfg_prdata);
          end
        end
      end

      if (in_tvalid && in_tready)
        placements_due.push_back(resolve_label(in_tdata[15:0], in_tdata[31:16], in_tlast));

      fail_count       <= fail_count + nfail;
      labels_in_flight <= placements_due.size();
    end
  end

endmodule

[test/label_overlap_resolver_tb.sv]
// Testbench top for the label overlap resolver: clock, reset, register setup,
// label stimulus and the verdict. Depends on lor_pkg, label_placement_checker and the RTL.
module label_overlap_resolver_tb;
  import lor_pkg::*;

  localparam int unsigned MAX_LABELS      = 64;
  localparam int unsigned MAX_PASSES      = 32;
  // worst single label: every pass walks the whole store
  localparam int unsigned DRAIN_CYCLES    = MAX_PASSES * (MAX_LABELS + 1) + 8;
  localparam int unsigned ITEMS_PER_PHASE = 160;
  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned HOLD_CYCLES     = 600;

  typedef enum logic [1:0] {FR_NOISE, FR_CLUSTER, FR_LONG, FR_STACK} frame_kind_t;

  logic              clk;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [31:0]       in_tdata    = '0;  // [15:0] anchor_x, [31:16] anchor_y
  logic              in_tlast    = 1'b0;  // frame_end
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [31:0]       out_tdata;  // [15:0] placed_x, [31:16] placed_y
  logic              out_tuser;  // store_full
  logic              out_tlast;  // frame_last
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr   = '0;
  logic [DATA_W-1:0] cfg_pwdata  = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  int   fail_count;
  int   labels_in_flight;

  // stimulus knobs, all updated on clock edges with nonblocking assignments
  logic quiet    = 1'b0;  // no idling on either side
  logic out_hold = 1'b0;  // receiver holds off completely
  int   phase_no = -1;

  // current gaps (size + padding), used to aim coordinates at collisions
  int   cur_gx = int'(WIDTH_RST) + int'(PAD_RST);
  int   cur_gy = int'(HEIGHT_RST) + int'(PAD_RST);

  label_overlap_resolver #(
    .MAX_LABELS (MAX_LABELS),
    .MAX_PASSES (MAX_PASSES)
  ) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  label_placement_checker #(
    .MAX_LABELS (MAX_LABELS),
    .MAX_PASSES (MAX_PASSES)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .in_tlast         (in_tlast),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .out_tuser        (out_tuser),
    .out_tlast        (out_tlast),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready),
    .fail_count       (fail_count),
    .labels_in_flight (labels_in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Receiver: drops tready about a third of the time, never while quiet,
  // and holds it low throughout the long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !out_hold && (quiet || $urandom_range(0, 99) >= 33);
    end
  end

  // Long receiver hold-off in phase 3: the sender keeps offering labels,
  // so the output register and the scan stage fill and in_tready drops.
  initial begin
    wait (phase_no == 3);
    out_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    out_hold <= 1'b0;
  end

  function automatic logic signed [15:0] clamp16(input int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // uniform in [-span, span]
  function automatic int jitter(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // APB write: setup, access, then idle with psel low so psel never toggles
  // twice in the same step on back-to-back calls.
  task automatic reg_write(input reg_idx_t idx, input logic [DATA_W-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // APB read; the checker compares prdata in the access cycle.
  task automatic reg_read(input reg_idx_t idx);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write all three sizes with junk above each field (must be masked off),
  // then read them back.
  task automatic set_sizes(input int unsigned w, input int unsigned h, input int unsigned p);
    reg_write(REG_WIDTH,   ($urandom << WIDTH_W)  | w);
    reg_write(REG_HEIGHT,  ($urandom << HEIGHT_W) | h);
    reg_write(REG_PADDING, ($urandom << PAD_W)    | p);
    reg_read(REG_WIDTH);
    reg_read(REG_HEIGHT);
    reg_read(REG_PADDING);
    cur_gx = w + p;
    cur_gy = h + p;
  endtask

  // One label transfer, with a random idle gap in front unless quiet.
  // tvalid stays high between back-to-back labels.
  task automatic send_label(input logic signed [15:0] ax, input logic signed [15:0] ay,
                            input logic fe);
    if (!quiet && $urandom_range(0, 99) < 33) begin
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom;
      in_tlast  <= 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {ay, ax};
    in_tlast  <= fe;
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop offering and wait until every placement has come back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (labels_in_flight != 0);
  endtask

  // One frame of labels.
  //   noise:   any coordinates, frame_end at random (store may carry over)
  //   cluster: short frame packed around one point so labels collide
  //   long:    more labels than the store holds, so the tail reports store_full
  //   stack:   same x, nearly same y: each label climbs the pile, the deep
  //            ones run out of passes
  task automatic send_frame(input frame_kind_t kind, inout int unsigned sent);
    int   len, k, cx, cy, wx, wy;
    logic fe;
    case (kind)
      FR_NOISE: len = $urandom_range(1, 8);
      FR_LONG:  len = $urandom_range(66, 72);
      FR_STACK: len = $urandom_range(34, 40);
      default:  len = $urandom_range(1, 20);
    endcase
    cx = jitter(32768);
    cy = jitter(32768);
    wx = ((kind == FR_LONG) ? 4 : 2) * cur_gx + 16;
    wy = ((kind == FR_LONG) ? 4 : 2) * cur_gy + 16;
    for (k = 0; k < len; k++) begin
      fe = (k == len - 1);
      case (kind)
        FR_NOISE:
          send_label(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     1'($urandom_range(0, 1)));
        FR_STACK:
          send_label(clamp16(cx), clamp16(cy + jitter(cur_gy / 2)), fe);
        default:
          send_label(clamp16(cx + jitter(wx)), clamp16(cy + jitter(wy)), fe);
      endcase
    end
    sent += len;
  endtask

  initial begin
    int unsigned sent, nframes, ph, pick;
    frame_kind_t kind;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed labels at the reset sizes (gap 1664 in x, 384 in y).
    send_label(16'sd0, 16'sd0, 1'b0);         // empty store: anchor passes through
    send_label(16'sd0, 16'sd0, 1'b0);         // same spot: pushed above the first
    send_label(16'sd1663, 16'sd0, 1'b0);      // x gap one short: climbs both
    send_label(16'sd1664, 16'sd100, 1'b0);    // x gap exact: no overlap
    send_label(16'sh8000, 16'sh7FFF, 1'b0);   // coordinate extremes
    send_label(16'sh7FFF, 16'sh8000, 1'b0);
    send_label(16'sd1664, 16'sd484, 1'b0);    // y gap exact: no overlap
    send_label(16'sd1664, 16'sd483, 1'b0);    // y gap one short: pushed
    send_label(16'sh7FFF, -16'sd32700, 1'b0); // push saturates at the bottom, runs out of passes
    send_label(16'sh8000, 16'sh8000, 1'b1);   // frame ends, store empties
    send_label(16'sd0, 16'sd0, 1'b1);         // single-label frame on an empty store
    send_label(16'sd0, 16'sd0, 1'b0);         // store empty again
    send_label(-16'sd1, -16'sd1, 1'b0);
    send_label(16'sd1, 16'sd1, 1'b1);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      // sender pauses until every placement is back; registers change only then
      wait_drained();
      case (ph)
        0: ;
        1: begin
          set_sizes(0, 0, 0);           // zero gaps: nothing can overlap
          reg_write(REG_NONE, $urandom);  // unmapped address, no effect
        end
        2: set_sizes(16383, 16383, 4095);
        5: set_sizes($urandom_range(0, 64), 0, 1);
        6: set_sizes($urandom_range(0, 16383), $urandom_range(0, 16383),
                     $urandom_range(0, 4095));
        default:
          set_sizes($urandom_range(0, 4095), $urandom_range(0, 1023),
                    $urandom_range(0, 255));
      endcase
      phase_no <= ph;
      quiet    <= (ph == 4);

      sent    = 0;
      nframes = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if (nframes == 0) begin
          kind = (ph % 2 == 0) ? FR_LONG : FR_STACK;
        end else begin
          pick = $urandom_range(0, 15);
          if (pick < 3)       kind = FR_NOISE;
          else if (pick == 3) kind = FR_LONG;
          else if (pick < 6)  kind = FR_STACK;
          else                kind = FR_CLUSTER;
        end
        send_frame(kind, sent);
        nframes++;
      end
    end

    wait_drained();
    // anything the block sends now is unexpected and gets flagged
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && labels_in_flight == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
